FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files. Each one is clocked on clk and
// is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHIP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SHIP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/ship_pkg.sv
`timescale 1ns / 1ps

package ship_pkg;

  localparam int NUM_SETS           = 2048;
  localparam int NUM_WAYS           = 16;
  localparam int LEADERS_PER_POLICY = 64;
  localparam int SIGNATURE_BITS     = 6;
  localparam int SELECTOR_BITS      = 10;

  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIGNATURE_BITS;

  localparam logic [1:0] RRPV_FAR  = 2'd3;
  localparam logic [1:0] RRPV_NEAR = 2'd2;
  localparam logic [1:0] CTR_MAX   = 2'd3;

  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] CFG_STREAM_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_BIMODAL_LOG2     = 2'd1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_SIG   = 8'b0000_1000,
    ST_AGE   = 8'b0001_0000,
    ST_FILL  = 8'b0010_0000,
    ST_DECAY = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

endpackage

FILE: sv/ship_drrip_stream_bypass_replacement.sv
`timescale 1ns / 1ps
// Sequence: a hit goes through READ, SIG and DONE; a miss goes on through AGE,
// FILL and DECAY, with 0 to 3 aging passes of the shared RRPV lane adder.
// Requests: one at a time; a new one is taken only in the IDLE state.
// Reset: rst_n is synchronous, active low. After reset a clearing pass over
// all NUM_SETS (2048) sets zeroes all set and signature memories; no request is
// taken meanwhile, configuration writes are taken at all times.
`include "assert_macros.svh"

module ship_drrip_stream_bypass_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_hit_way,
  input  logic [63:0] in_address,
  input  logic [63:0] in_pc,
  input  logic        in_is_hit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_victim_way,
  output logic        out_streaming,
  output logic [1:0]  out_inserted_rrpv,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int NW  = ship_pkg::NUM_WAYS;
  localparam int SB  = ship_pkg::SIGNATURE_BITS;
  localparam int STB = ship_pkg::SET_BITS;
  localparam int WB  = ship_pkg::WAY_BITS;
  localparam int SLB = ship_pkg::SELECTOR_BITS;

  // Set metadata memories: one row per set holds every way's field.
  logic [2*NW-1:0]  rrpv_mem  [ship_pkg::NUM_SETS];
  logic [2*NW-1:0]  reuse_mem [ship_pkg::NUM_SETS];
  logic [SB*NW-1:0] bsig_mem  [ship_pkg::NUM_SETS];
  // Per-set stride detector memories.
  logic [63:0]      last_addr_mem   [ship_pkg::NUM_SETS];
  logic [63:0]      last_stride_mem [ship_pkg::NUM_SETS];
  logic [1:0]       conf_mem        [ship_pkg::NUM_SETS];
  // Signature counters.
  logic [1:0]       sc_mem [ship_pkg::SIG_COUNT];

  ship_pkg::state_t state_r, state_nxt;

  logic [1:0]       thr_r;
  logic [2:0]       bcl_r;
  logic [STB-1:0]   clr_cnt_r;
  logic [STB-1:0]   set_r;
  logic [WB-1:0]    hit_way_r;
  logic [63:0]      addr_r;
  logic [SB-1:0]    sig_r;
  logic             is_hit_r;
  logic             streaming_r;

  logic [2*NW-1:0]  rrpv_rd_r, reuse_rd_r, rrpv_w_r;
  logic [SB*NW-1:0] bsig_rd_r;
  logic [63:0]      last_addr_rd_r, last_stride_rd_r;
  logic [1:0]       conf_rd_r;
  logic [1:0]       sc_rd_r, sc_new_r;

  logic [WB-1:0]    victim_r;
  logic [1:0]       depth_r;
  logic             decay_r;
  logic [SLB-1:0]   sel_r;
  logic [15:0]      lfsr_r;

  logic             out_valid_r;
  logic [3:0]       out_victim_way_r;
  logic             out_streaming_r;
  logic [1:0]       out_inserted_rrpv_r;

  logic             accept;
  logic             srrip_leader, brrip_leader;

  // Memory write ports.
  logic             row_we;
  logic [STB-1:0]   row_waddr;
  logic [2*NW-1:0]  rrpv_wd, reuse_wd;
  logic [SB*NW-1:0] bsig_wd;
  logic             st_we;
  logic [STB-1:0]   st_waddr;
  logic [63:0]      st_addr_wd, st_stride_wd;
  logic [1:0]       st_conf_wd;
  logic             sc_we;
  logic [SB-1:0]    sc_waddr, sc_raddr;
  logic [1:0]       sc_wd;

  // Stream detector datapath: one 64-bit subtract and its compares.
  logic [63:0]      stride;
  logic             stride_match;
  logic [1:0]       conf_new;

  // Shared RRPV lane unit: far-way search and one aging step.
  logic             any_far;
  logic [WB-1:0]    first_far;
  logic [2*NW-1:0]  rrpv_aged, rrpv_hit_row, reuse_hit_row;

  // Fill depth.
  logic [15:0]      lfsr_step, bim_mask;
  logic             draw_needed;
  logic [1:0]       draw, depth_fill;
  logic [1:0]       victim_reuse, hit_reuse;
  logic [SB-1:0]    old_sig;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ship_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_victim_way    = out_victim_way_r;
  assign out_streaming     = out_streaming_r;
  assign out_inserted_rrpv = out_inserted_rrpv_r;

  assign srrip_leader = (32'(set_r) < ship_pkg::LEADERS_PER_POLICY);
  assign brrip_leader = !srrip_leader && (32'(set_r) < 2 * ship_pkg::LEADERS_PER_POLICY);

  // The stride is taken against the stored last address of the set; a zero
  // last address means the set has not been seen since reset.
  assign stride       = addr_r - last_addr_rd_r;
  assign stride_match = (last_addr_rd_r != 64'd0) && (stride != 64'd0) &&
                        (stride == last_stride_rd_r);
  always_comb begin
    conf_new = conf_rd_r;
    if (stride_match) begin
      if (conf_rd_r != ship_pkg::CTR_MAX) conf_new = conf_rd_r + 2'd1;
    end else if (conf_rd_r != 2'd0) begin
      conf_new = conf_rd_r - 2'd1;
    end
  end

  // Lane logic over the working RRPV row. The aging step raises every way by
  // one; it is only applied while no way is at the far value, so no lane
  // overflows.
  always_comb begin
    any_far   = 1'b0;
    first_far = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (rrpv_w_r[2*w +: 2] == ship_pkg::RRPV_FAR) begin
        any_far   = 1'b1;
        first_far = WB'(w);
      end
    end
    for (int w = 0; w < NW; w++) begin
      rrpv_aged[2*w +: 2] = rrpv_w_r[2*w +: 2] + 2'd1;
    end
  end

  assign hit_reuse = reuse_rd_r[2*hit_way_r +: 2];
  always_comb begin
    rrpv_hit_row  = rrpv_w_r;
    reuse_hit_row = reuse_rd_r;
    rrpv_hit_row[2*hit_way_r +: 2] = 2'd0;
    if (hit_reuse != ship_pkg::CTR_MAX) reuse_hit_row[2*hit_way_r +: 2] = hit_reuse + 2'd1;
  end

  assign victim_reuse = reuse_rd_r[2*victim_r +: 2];
  assign old_sig      = bsig_rd_r[SB*victim_r +: SB];

  // BRRIP draw: the LFSR steps only when a draw is actually made.
  assign lfsr_step   = (lfsr_r >> 1) ^ (lfsr_r[0] ? ship_pkg::LFSR_TAPS : 16'd0);
  assign bim_mask    = (16'd1 << bcl_r) - 16'd1;
  assign draw        = ((lfsr_step & bim_mask) == 16'd0) ? ship_pkg::RRPV_NEAR
                                                         : ship_pkg::RRPV_FAR;
  assign draw_needed = brrip_leader || (!srrip_leader && (sel_r < ship_pkg::SEL_MID));
  always_comb begin
    if (draw_needed) depth_fill = draw;
    else depth_fill = ship_pkg::RRPV_NEAR;
    if (streaming_r || (victim_reuse == 2'd0) || (sc_new_r == 2'd0)) begin
      depth_fill = ship_pkg::RRPV_FAR;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ship_pkg::ST_CLEAR: begin
        if (32'(clr_cnt_r) == ship_pkg::NUM_SETS - 1) state_nxt = ship_pkg::ST_IDLE;
      end
      ship_pkg::ST_IDLE: begin
        if (accept) state_nxt = ship_pkg::ST_READ;
      end
      ship_pkg::ST_READ:  state_nxt = ship_pkg::ST_SIG;
      ship_pkg::ST_SIG:   state_nxt = is_hit_r ? ship_pkg::ST_DONE : ship_pkg::ST_AGE;
      ship_pkg::ST_AGE: begin
        if (any_far || streaming_r) state_nxt = ship_pkg::ST_FILL;
      end
      ship_pkg::ST_FILL:  state_nxt = ship_pkg::ST_DECAY;
      ship_pkg::ST_DECAY: state_nxt = ship_pkg::ST_DONE;
      ship_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ship_pkg::ST_IDLE;
      end
      default: state_nxt = ship_pkg::ST_CLEAR;
    endcase
  end

  // Memory write port selection.
  always_comb begin
    row_we       = 1'b0;
    row_waddr    = set_r;
    rrpv_wd      = rrpv_w_r;
    reuse_wd     = reuse_rd_r;
    bsig_wd      = bsig_rd_r;
    st_we        = 1'b0;
    st_waddr     = set_r;
    st_addr_wd   = addr_r;
    st_stride_wd = stride;
    st_conf_wd   = conf_new;
    sc_we        = 1'b0;
    sc_waddr     = sig_r;
    sc_wd        = sc_rd_r;
    sc_raddr     = sig_r;
    if (state_r == ship_pkg::ST_CLEAR) begin
      row_we       = 1'b1;
      row_waddr    = clr_cnt_r;
      rrpv_wd      = '0;
      reuse_wd     = '0;
      bsig_wd      = '0;
      st_we        = 1'b1;
      st_waddr     = clr_cnt_r;
      st_addr_wd   = '0;
      st_stride_wd = '0;
      st_conf_wd   = '0;
      sc_we        = (32'(clr_cnt_r) < ship_pkg::SIG_COUNT);
      sc_waddr     = clr_cnt_r[SB-1:0];
      sc_wd        = '0;
    end
    if (state_r == ship_pkg::ST_READ) begin
      st_we = 1'b1;
    end
    if ((state_r == ship_pkg::ST_SIG) && is_hit_r) begin
      row_we   = 1'b1;
      rrpv_wd  = rrpv_hit_row;
      reuse_wd = reuse_hit_row;
      sc_we    = 1'b1;
      if (sc_rd_r != ship_pkg::CTR_MAX) sc_wd = sc_rd_r + 2'd1;
    end
    if (state_r == ship_pkg::ST_FILL) begin
      row_we = 1'b1;
      rrpv_wd[2*victim_r +: 2]   = depth_fill;
      reuse_wd[2*victim_r +: 2]  = 2'd0;
      bsig_wd[SB*victim_r +: SB] = sig_r;
      sc_raddr = old_sig;
    end
    if (state_r == ship_pkg::ST_DECAY) begin
      sc_waddr = bsig_rd_r[SB*victim_r +: SB];
      sc_we    = decay_r && (sc_rd_r != 2'd0);
      sc_wd    = sc_rd_r - 2'd1;
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (row_we) begin
      rrpv_mem[row_waddr]  <= rrpv_wd;
      reuse_mem[row_waddr] <= reuse_wd;
      bsig_mem[row_waddr]  <= bsig_wd;
    end
    if (accept) begin
      rrpv_rd_r  <= rrpv_mem[in_set_index[STB-1:0]];
      reuse_rd_r <= reuse_mem[in_set_index[STB-1:0]];
      bsig_rd_r  <= bsig_mem[in_set_index[STB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      last_addr_mem[st_waddr]   <= st_addr_wd;
      last_stride_mem[st_waddr] <= st_stride_wd;
      conf_mem[st_waddr]        <= st_conf_wd;
    end
    if (accept) begin
      last_addr_rd_r   <= last_addr_mem[in_set_index[STB-1:0]];
      last_stride_rd_r <= last_stride_mem[in_set_index[STB-1:0]];
      conf_rd_r        <= conf_mem[in_set_index[STB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[sc_waddr] <= sc_wd;
    sc_rd_r <= sc_mem[sc_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ship_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      thr_r       <= 2'd2;
      bcl_r       <= 3'd5;
      sel_r       <= ship_pkg::SEL_MID;
      lfsr_r      <= ship_pkg::LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ship_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ship_pkg::CFG_STREAM_THRESHOLD: thr_r <= cfg_data[1:0];
          ship_pkg::CFG_BIMODAL_LOG2:     bcl_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      // The duel selector moves on hits and misses in leader sets, in
      // opposite directions.
      if ((state_r == ship_pkg::ST_SIG) && is_hit_r) begin
        if (srrip_leader && (sel_r != ship_pkg::SEL_MAX)) sel_r <= sel_r + 1'b1;
        else if (brrip_leader && (sel_r != '0)) sel_r <= sel_r - 1'b1;
      end
      if (state_r == ship_pkg::ST_FILL) begin
        if (srrip_leader && (sel_r != '0)) sel_r <= sel_r - 1'b1;
        else if (brrip_leader && (sel_r != ship_pkg::SEL_MAX)) sel_r <= sel_r + 1'b1;
        if (draw_needed) lfsr_r <= lfsr_step;
      end
      if ((state_r == ship_pkg::ST_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and working payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r     <= in_set_index[STB-1:0];
      hit_way_r <= in_hit_way[WB-1:0];
      addr_r    <= in_address;
      sig_r     <= in_pc[SB-1:0] ^ in_pc[SB+3:4];
      is_hit_r  <= in_is_hit;
    end
    unique case (state_r)
      ship_pkg::ST_READ: begin
        rrpv_w_r    <= rrpv_rd_r;
        streaming_r <= (conf_new >= thr_r);
      end
      ship_pkg::ST_SIG: begin
        sc_new_r <= sc_rd_r;
        victim_r <= hit_way_r;
        depth_r  <= 2'd0;
      end
      ship_pkg::ST_AGE: begin
        // Streaming bypass with no far way: whole set goes far, way 0 taken.
        if (any_far) begin
          victim_r <= first_far;
        end else if (streaming_r) begin
          rrpv_w_r <= {NW{ship_pkg::RRPV_FAR}};
          victim_r <= '0;
        end else begin
          rrpv_w_r <= rrpv_aged;
        end
      end
      ship_pkg::ST_FILL: begin
        depth_r <= depth_fill;
        decay_r <= (victim_reuse == 2'd0);
      end
      ship_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_victim_way_r    <= 4'(victim_r);
          out_streaming_r     <= streaming_r;
          out_inserted_rrpv_r <= depth_r;
        end
      end
      default: ;
    endcase
  end

  // A miss always evicts a way that sits at the far value after the scan.
  `SHIP_ASSERT_IMP(a_victim_far, state_r == ship_pkg::ST_FILL, rrpv_w_r[2*victim_r +: 2] == ship_pkg::RRPV_FAR)
  // An accepted request always starts with the metadata read.
  `SHIP_ASSERT_NXT(a_accept_read, accept, state_r == ship_pkg::ST_READ)
  // A hit result always reports the near-most depth.
  `SHIP_ASSERT_IMP(a_hit_depth, (state_r == ship_pkg::ST_DONE) && is_hit_r, depth_r == 2'd0)

endmodule
